// ===== src/pxsc_pkg.sv =====
package pxsc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned PAD_W     = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_SEND       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECV       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVER_KEY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KEY = 1'b1;

    localparam logic [WORD_W-1:0] MUL_CONST      = 32'd241103;
    localparam logic [WORD_W-1:0] ADD_CONST      = 32'd2533101;
    localparam logic [WORD_W-1:0] INIT_KEY_RESET = 32'h6079_8607;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] data_word;
        logic              end_of_packet;
        logic [PAD_W-1:0]  pad_bytes;
    } pxsc_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              result_last;
    } pxsc_out_t;

    // key state carried between words
    typedef struct packed {
        logic [WORD_W-1:0] send_key;
        logic [WORD_W-1:0] recv_key;
        logic [WORD_W-1:0] server_key;
        logic              first_done;
    } pxsc_state_t;

    typedef struct packed {
        logic        has_result;
        pxsc_out_t   result;
        pxsc_state_t state_next;
    } pxsc_core_out_t;

    function automatic logic [HALF_W-1:0] half_map(input logic [HALF_W-1:0] x);
        logic [WORD_W-1:0] v;
        v = WORD_W'(WORD_W'(x) * MUL_CONST + ADD_CONST);
        return v[WORD_W-1:HALF_W];
    endfunction

    function automatic logic [WORD_W-1:0] derive_key(input logic [WORD_W-1:0] cipher,
                                                     input logic [WORD_W-1:0] pkt_key);
        return {half_map(cipher[WORD_W-1:HALF_W]), half_map(cipher[HALF_W-1:0])} ^ pkt_key;
    endfunction

    // top bytes taken from the key on a padded last receive word
    function automatic logic [WORD_W-1:0] pad_mask(input logic [PAD_W-1:0] pad);
        logic [WORD_W-1:0] m;
        unique case (pad)
            2'd0: m = 32'h0000_0000;
            2'd1: m = 32'hFF00_0000;
            2'd2: m = 32'hFFFF_0000;
            2'd3: m = 32'hFFFF_FF00;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== src/pxsc_core.sv =====
module pxsc_core (
    input  pxsc_pkg::pxsc_in_t          item,
    input  pxsc_pkg::pxsc_state_t       state,
    input  logic [pxsc_pkg::WORD_W-1:0] packet_key,
    output pxsc_pkg::pxsc_core_out_t    core_out
);

    logic [pxsc_pkg::WORD_W-1:0] mask;
    logic [pxsc_pkg::WORD_W-1:0] recv_word;
    logic [pxsc_pkg::WORD_W-1:0] send_res;
    logic [pxsc_pkg::WORD_W-1:0] recv_res;
    logic [pxsc_pkg::WORD_W-1:0] recv_key_new;

    always_comb begin
        mask = item.end_of_packet ? pxsc_pkg::pad_mask(item.pad_bytes) : '0;
        recv_word = (item.data_word & ~mask) | (state.recv_key & mask);
        send_res = item.data_word ^ state.send_key;
        recv_res = recv_word ^ state.recv_key;
        recv_key_new = pxsc_pkg::derive_key(recv_word, packet_key);
    end

    always_comb begin
        core_out.has_result         = 1'b0;
        core_out.result.result_word = send_res;
        core_out.result.result_last = item.end_of_packet;
        core_out.state_next         = state;
        unique case (item.command)
            pxsc_pkg::CMD_SEND: begin
                core_out.has_result          = 1'b1;
                core_out.state_next.send_key = pxsc_pkg::derive_key(send_res, packet_key);
            end
            pxsc_pkg::CMD_RECV: begin
                core_out.has_result          = 1'b1;
                core_out.result.result_word  = recv_res;
                core_out.state_next.recv_key = recv_key_new;
                // first receive packet closes: merge the server key into both keys
                if (item.end_of_packet && !state.first_done) begin
                    core_out.state_next.recv_key   = recv_key_new | state.server_key;
                    core_out.state_next.send_key   = state.send_key | state.server_key;
                    core_out.state_next.first_done = 1'b1;
                end
            end
            pxsc_pkg::CMD_SERVER_KEY: begin
                if (!state.first_done) begin
                    core_out.state_next.server_key = item.data_word;
                end
            end
            default: begin
                core_out.has_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/packet_xor_stream_cipher_top.sv =====
// Word-wise XOR stream cipher with ciphertext feedback, separate send and
// receive keys.
// s_ channel: one beat per word (command, data_word, end_of_packet,
// pad_bytes). Send and receive beats each give one m_ beat (result_word,
// result_last); server key beats and unused commands give none.
// cfg channel: cfg_index 0 writes packet_key, 1 writes initial_key and
// restarts the session (both keys reloaded, server key cleared). cfg_ready
// is always high; write only while no word is in flight.
// Path: a beat taken on s_ waits in the input register, and its result is
// registered into the result register on m_. One word per cycle while m_ready
// is high: each word's key update (two 16x18 constant multiplies, add, XOR)
// completes as it leaves the input register, so the next word sees the new key.
// Reset: synchronous, active low; keys load 0x60798607, packet_key 0,
// both stages empty.
// Stall: with m_ready low the result register holds, and s_ready drops once
// the input register holds a send or receive word, until m_ready returns.
module packet_xor_stream_cipher_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pxsc_pkg::pxsc_in_t             s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pxsc_pkg::pxsc_out_t            m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pxsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pxsc_pkg::WORD_W-1:0]    cfg_data
);

    pxsc_pkg::pxsc_in_t          in_reg;
    logic                        in_valid_reg, in_valid_next;
    pxsc_pkg::pxsc_out_t         out_reg;
    logic                        out_valid_reg, out_valid_next;
    pxsc_pkg::pxsc_state_t       state_reg, state_next;
    logic [pxsc_pkg::WORD_W-1:0] packet_key_reg;
    logic [pxsc_pkg::WORD_W-1:0] initial_key_reg;
    pxsc_pkg::pxsc_core_out_t    core_out;
    logic                        out_free;
    logic                        stage_fire;
    logic                        cfg_write;

    pxsc_core u_core (
        .item       (in_reg),
        .state      (state_reg),
        .packet_key (packet_key_reg),
        .core_out   (core_out)
    );

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign stage_fire = in_valid_reg && (!core_out.has_result || out_free);
    assign s_ready    = !in_valid_reg || stage_fire;
    assign m_valid    = out_valid_reg;
    assign m_payload  = out_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (stage_fire && core_out.has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        if (cfg_write && cfg_index == pxsc_pkg::CFG_INITIAL_KEY) begin
            state_next.send_key   = cfg_data;
            state_next.recv_key   = cfg_data;
            state_next.server_key = '0;
            state_next.first_done = 1'b0;
        end else if (stage_fire) begin
            state_next = core_out.state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            packet_key_reg       <= '0;
            initial_key_reg      <= pxsc_pkg::INIT_KEY_RESET;
            state_reg.send_key   <= pxsc_pkg::INIT_KEY_RESET;
            state_reg.recv_key   <= pxsc_pkg::INIT_KEY_RESET;
            state_reg.server_key <= '0;
            state_reg.first_done <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    pxsc_pkg::CFG_PACKET_KEY:  packet_key_reg  <= cfg_data;
                    pxsc_pkg::CFG_INITIAL_KEY: initial_key_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (stage_fire && core_out.has_result) begin
            out_reg <= core_out.result;
        end
    end

`ifndef SYNTHESIS
    // session flag only clears on a restart through initial_key
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(state_reg.first_done) |->
            $past(cfg_write && cfg_index == pxsc_pkg::CFG_INITIAL_KEY))
        else $error("first packet flag cleared without restart");

    // server key is frozen from the end of the first receive packet until a restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(state_reg.server_key) |->
            (!$past(state_reg.first_done) || $past(cfg_write)))
        else $error("server key changed after first packet");

    // a result beat only appears from a word in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && core_out.has_result))
        else $error("result beat without source word");

    // initial_key register and live keys agree right after a restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cfg_write && cfg_index == pxsc_pkg::CFG_INITIAL_KEY) |->
            (state_reg.send_key == initial_key_reg &&
             state_reg.recv_key == initial_key_reg))
        else $error("keys not reloaded on restart");
`endif

endmodule

// ===== verif/pxsc_cipher_sb_pkg.sv =====
`timescale 1ns / 1ps

package pxsc_cipher_sb_pkg;

    import pxsc_pkg::*;

    // command 3 is not decoded by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class cipher_scoreboard;

        logic [WORD_W-1:0] packet_key;
        logic [WORD_W-1:0] initial_key;
        logic [WORD_W-1:0] send_key;
        logic [WORD_W-1:0] recv_key;
        logic [WORD_W-1:0] server_key;
        logic              first_done;

        pxsc_out_t expected_words[$];

        int mismatches;
        int reported;
        int words_checked;
        int send_words;
        int recv_words;
        int server_words;
        int unused_words;
        int reg_writes;

        function new();
            packet_key    = '0;
            initial_key   = INIT_KEY_RESET;
            mismatches    = 0;
            reported      = 0;
            words_checked = 0;
            send_words    = 0;
            recv_words    = 0;
            server_words  = 0;
            unused_words  = 0;
            reg_writes    = 0;
            restart_session();
        endfunction

        function void restart_session();
            send_key   = initial_key;
            recv_key   = initial_key;
            server_key = '0;
            first_done = 1'b0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
            reg_writes++;
            case (idx)
                CFG_PACKET_KEY: packet_key = val;
                CFG_INITIAL_KEY: begin
                    initial_key = val;
                    restart_session();
                end
                default: ;
            endcase
        endfunction

        function logic [HALF_W-1:0] scramble_half(input logic [HALF_W-1:0] x);
            logic [WORD_W-1:0] v;
            v = {{(WORD_W-HALF_W){1'b0}}, x} * MUL_CONST + ADD_CONST;
            return v[WORD_W-1:HALF_W];
        endfunction

        // next key from the ciphertext word of that direction
        function logic [WORD_W-1:0] chain_key(input logic [WORD_W-1:0] cipher);
            logic [WORD_W-1:0] k;
            k[HALF_W-1:0]      = scramble_half(cipher[HALF_W-1:0]);
            k[WORD_W-1:HALF_W] = scramble_half(cipher[WORD_W-1:HALF_W]);
            return k ^ packet_key;
        endfunction

        function void note_word(input pxsc_in_t w);
            logic [WORD_W-1:0] word;
            logic [WORD_W-1:0] top_mask;
            pxsc_out_t         res;
            res.result_last = w.end_of_packet;
            case (w.command)
                CMD_SEND: begin
                    send_words++;
                    res.result_word = w.data_word ^ send_key;
                    send_key = chain_key(res.result_word);
                    expected_words.push_back(res);
                end
                CMD_RECV: begin
                    recv_words++;
                    word = w.data_word;
                    if (w.end_of_packet) begin
                        // padding bytes at the top take the key bytes
                        top_mask = ~(32'hFFFF_FFFF >> (8 * int'(w.pad_bytes)));
                        word = (word & ~top_mask) | (recv_key & top_mask);
                    end
                    res.result_word = word ^ recv_key;
                    recv_key = chain_key(word);
                    if (w.end_of_packet && !first_done) begin
                        recv_key   = recv_key | server_key;
                        send_key   = send_key | server_key;
                        first_done = 1'b1;
                    end
                    expected_words.push_back(res);
                end
                CMD_SERVER_KEY: begin
                    server_words++;
                    if (!first_done)
                        server_key = w.data_word;
                end
                default: unused_words++;
            endcase
        endfunction

        function void check_result(input pxsc_out_t got);
            pxsc_out_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] result beat with nothing expected: word=%h last=%b",
                             $realtime, got.result_word, got.result_last);
                end
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.result_word !== want.result_word || got.result_last !== want.result_last) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] result %0d mismatch: word exp=%h act=%h, last exp=%b act=%b",
                             $realtime, words_checked, want.result_word, got.result_word,
                             want.result_last, got.result_last);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int failures();
            return mismatches + expected_words.size();
        endfunction

    endclass

endpackage

// ===== verif/tb_packet_xor_stream_cipher_top.sv =====
`timescale 1ns / 1ps

module tb_packet_xor_stream_cipher_top;

    import pxsc_pkg::*;
    import pxsc_cipher_sb_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    pxsc_in_t             s_payload;
    logic                 m_valid;
    logic                 m_ready;
    pxsc_out_t            m_payload;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    cipher_scoreboard board;
    int send_calm;
    int settings_run;

    packet_xor_stream_cipher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("tb_packet_xor_stream_cipher_top: done, errors");
        $finish;
    end

    function automatic pxsc_in_t mk_word(input logic [CMD_W-1:0] cmd,
                                         input logic [WORD_W-1:0] data,
                                         input logic last, input logic [PAD_W-1:0] pad);
        pxsc_in_t w;
        w.command       = cmd;
        w.data_word     = data;
        w.end_of_packet = last;
        w.pad_bytes     = pad;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] rand_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic int sender_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            send_calm = $urandom_range(30, 120);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // valid stays high after a beat; the next call either lowers it or
    // presents the next word in the same step
    task automatic push_word(input pxsc_in_t w);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
    endtask

    // drain before touching the registers; trailing server key beats give no
    // result, so allow the pipeline depth on top
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic do_pkt, input logic [WORD_W-1:0] pkt,
                              input logic do_init, input logic [WORD_W-1:0] init_val);
        if (do_pkt) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_PACKET_KEY;
            cfg_data  <= pkt;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            board.write_reg(CFG_PACKET_KEY, pkt);
        end
        if (do_init) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INITIAL_KEY;
            cfg_data  <= init_val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            board.write_reg(CFG_INITIAL_KEY, init_val);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic random_phase(input int n_words, input logic fresh_session);
        int made;
        int len;
        int r;
        logic [CMD_W-1:0] dir;
        made = 0;
        if (fresh_session && $urandom_range(0, 9) < 7)
            push_word(mk_word(CMD_SERVER_KEY, rand_data(), 1'($urandom), 2'($urandom)));
        while (made < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_word(mk_word(CMD_SERVER_KEY, rand_data(), 1'($urandom), 2'($urandom)));
            end else if (r < 10) begin
                push_word(mk_word(CMD_UNUSED, rand_data(), 1'($urandom), 2'($urandom)));
            end else begin
                dir = ($urandom_range(0, 1) != 0) ? CMD_RECV : CMD_SEND;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_word(mk_word(dir, rand_data(), 1'(i == len - 1), 2'($urandom)));
                made += len;
            end
        end
    endtask

    // result side: random stalls, calm stretches, and two long hold-offs
    // while the sender keeps offering
    initial begin
        int stall_left;
        int calm_left;
        int seen;
        int r;
        stall_left = 0;
        calm_left  = 0;
        seen       = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_result(m_payload);
                seen++;
                if (seen == 400 || seen == 1200)
                    stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 18)
                        stall_left = $urandom_range(8, 40);
                    else if (r < 20)
                        calm_left = $urandom_range(50, 200);
                end
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] pk;
        logic [WORD_W-1:0] ik;
        logic              do_init;
        board        = new();
        send_calm    = 0;
        settings_run = 1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PACKET_KEY;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset keys: server key taken, first receive packet closes with padding
        push_word(mk_word(CMD_SEND, 32'h0000_0000, 1'b0, 2'd0));
        push_word(mk_word(CMD_SEND, 32'hFFFF_FFFF, 1'b1, 2'd3));
        push_word(mk_word(CMD_SERVER_KEY, 32'h0F0F_00F0, 1'b0, 2'd0));
        push_word(mk_word(CMD_RECV, 32'h1234_5678, 1'b0, 2'd2));
        push_word(mk_word(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 2'd3));
        push_word(mk_word(CMD_RECV, 32'hFFFF_FFFF, 1'b1, 2'd1));
        // late server key must be ignored
        push_word(mk_word(CMD_SERVER_KEY, 32'hFFFF_FFFF, 1'b1, 2'd0));
        push_word(mk_word(CMD_SEND, 32'hA5A5_A5A5, 1'b1, 2'd0));
        push_word(mk_word(CMD_RECV, 32'h0000_0000, 1'b1, 2'd0));
        push_word(mk_word(CMD_RECV, 32'hDEAD_BEEF, 1'b1, 2'd2));
        push_word(mk_word(CMD_RECV, 32'hFFFF_FFFF, 1'b1, 2'd3));
        settle();

        set_config(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        push_word(mk_word(CMD_SERVER_KEY, 32'h0000_0000, 1'b0, 2'd0));
        push_word(mk_word(CMD_RECV, 32'h0000_0000, 1'b0, 2'd3));
        push_word(mk_word(CMD_RECV, 32'hFFFF_FFFF, 1'b1, 2'd3));
        push_word(mk_word(CMD_SEND, 32'h0000_0000, 1'b0, 2'd0));
        push_word(mk_word(CMD_SEND, 32'hFFFF_FFFF, 1'b1, 2'd0));
        settle();

        set_config(1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        push_word(mk_word(CMD_RECV, 32'hABCD_EF01, 1'b1, 2'd0));
        push_word(mk_word(CMD_SEND, 32'h0000_0001, 1'b1, 2'd0));
        push_word(mk_word(CMD_SERVER_KEY, 32'h8000_0001, 1'b0, 2'd0));
        push_word(mk_word(CMD_RECV, 32'h8000_0000, 1'b1, 2'd3));
        settle();

        for (int p = 0; p < 7; p++) begin
            do_init = (p % 3 != 1);
            pk = (p == 1) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0000_0000 : rand_data();
            ik = (p == 2) ? 32'h0000_0000 : (p == 3) ? 32'hFFFF_FFFF : rand_data();
            set_config(1'b1, pk, do_init, ik);
            random_phase(250, do_init);
            settle();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d send, %0d receive, %0d server key and %0d unused words",
                 board.send_words, board.recv_words, board.server_words, board.unused_words);
        $display("%0d results checked over %0d register settings (%0d writes), %0d mismatches",
                 board.words_checked, settings_run, board.reg_writes, board.mismatches);
        if (board.failures() == 0)
            $display("tb_packet_xor_stream_cipher_top: done, clean");
        else
            $display("tb_packet_xor_stream_cipher_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/pxsc_pkg.sv
src/pxsc_core.sv
src/packet_xor_stream_cipher_top.sv
verif/pxsc_cipher_sb_pkg.sv
verif/tb_packet_xor_stream_cipher_top.sv
